FILE: rtl/core/ctb_pkg.sv
// Shared constants and types for the Cartesian tree builder.
// No dependencies; used by every module under rtl/core.
`default_nettype none
package ctb_pkg;
	localparam int NODES_DEF = 256;
	localparam int KEY_BITS_DEF = 32;
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	// Per-node link record.
	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic has_left;
		logic [IDX_W-1:0] right;
		logic has_right;
		logic [IDX_W-1:0] parent;
		logic has_parent;
	} links_t;
endpackage
`default_nettype wire

FILE: rtl/core/ctb_cell.sv
// One spine stack cell: holds one key and node index and shifts with its neighbours.
// Depends on ctb_pkg.
`default_nettype none
module ctb_cell #(
	parameter int KEY_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic pop,
	input wire logic clear,
	input wire logic [KEY_BITS-1:0] below_key,
	input wire logic [ctb_pkg::IDX_W-1:0] below_node,
	input wire logic below_vld,
	input wire logic [KEY_BITS-1:0] above_key,
	input wire logic [ctb_pkg::IDX_W-1:0] above_node,
	input wire logic above_vld,
	output logic [KEY_BITS-1:0] key_q,
	output logic [ctb_pkg::IDX_W-1:0] node_q,
	output logic vld_q
);
	import ctb_pkg::*;
	// Cell 0 is the top of the stack; a push shifts down, a pop shifts up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clear) begin
			vld_q <= 1'b0;
		end else if (push) begin
			vld_q <= above_vld;
		end else if (pop) begin
			vld_q <= below_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (push) begin
			key_q <= above_key;
			node_q <= above_node;
		end else if (pop) begin
			key_q <= below_key;
			node_q <= below_node;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/cartesian_tree_builder.sv
// Top level of the Cartesian tree builder: control sequencer, link memory, spine cells.
// Depends on ctb_pkg and ctb_cell.
//
// Each transfer yields exactly one result. A clear, an out-of-range query, a rejected append
// or an unused action code goes straight from IDLE to the OUT state. A query of a present
// node passes through READ on the way. An append stays in POP while it pops spine nodes,
// then goes on through READ to OUT. Each node is popped at most once. The spine is a chain
// of NODES cells shifting one place per cycle while they push or pop. The links live in a
// memory with registered reads, one following the top of the spine and one at the item's
// node. The result sits in an output register. A new item can be taken in the cycle in which
// that register is handed on, so a stalled result holds off the input.
`default_nettype none
module cartesian_tree_builder
	import ctb_pkg::*;
#(
	parameter int NODES = NODES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] action,
	input wire logic signed [31:0] value,
	input wire logic [7:0] query_index,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] node_index,
	output logic [7:0] left_child,
	output logic has_left,
	output logic [7:0] right_child,
	output logic has_right,
	output logic [7:0] parent_node,
	output logic has_parent,
	output logic [7:0] root_node,
	output logic has_root,
	output logic [8:0] node_count,
	output logic [1:0] status
);
	localparam int AW = (NODES > 256) ? 8 : $clog2(NODES);

	typedef enum logic [1:0] {S_IDLE, S_POP, S_READ, S_OUT} state_t;
	state_t state_q;

	logic order_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] root_q;
	logic root_vld_q;
	logic [KEY_BITS-1:0] key_q;
	logic [1:0] act_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cand_q;
	logic cand_vld_q;
	logic [1:0] st_q;

	links_t mem [2**AW];
	links_t rd_q;
	links_t top_rec_q;
	links_t cand_rec_q;

	logic [KEY_BITS-1:0] ck [NODES+1];
	logic [IDX_W-1:0] cn [NODES+1];
	logic cv [NODES+1];
	logic push, pop, clr;

	logic full;
	logic keep;
	logic take;

	assign take = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign full = (int'(count_q) >= NODES) || (count_q >= CNT_W'(256));
	// Key ordered as unsigned by flipping the sign bit.
	assign keep = order_q ? (ck[0] > key_q) : (ck[0] < key_q);

	assign ck[NODES] = '0;
	assign cn[NODES] = '0;
	assign cv[NODES] = 1'b0;
	assign push = (state_q == S_POP) && !(cv[1] && !keep && cv[0]) && (!cv[0] || keep);

	// Top element is held in the chain at the head position: ck[0] is cell 0.
	genvar g;
	generate
		for (g = 0; g < NODES; g++) begin : g_cell
			ctb_cell #(.KEY_BITS(KEY_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n),
				.push(push), .pop(pop), .clear(clr),
				.below_key(ck[g+1]), .below_node(cn[g+1]), .below_vld(cv[g+1]),
				.above_key((g == 0) ? key_q : ck[(g == 0) ? 0 : g-1]),
				.above_node((g == 0) ? count_q[IDX_W-1:0] : cn[(g == 0) ? 0 : g-1]),
				.above_vld((g == 0) ? 1'b1 : cv[(g == 0) ? 0 : g-1]),
				.key_q(ck[g]), .node_q(cn[g]), .vld_q(cv[g])
			);
		end
	endgenerate

	assign pop = (state_q == S_POP) && cv[0] && !keep;
	assign clr = take && (action == ACT_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			root_vld_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						act_q <= action;
						key_q <= KEY_BITS'(value) ^ (KEY_BITS'(1) << (KEY_BITS - 1));
						cand_vld_q <= 1'b0;
						idx_q <= (action == ACT_APPEND) ? count_q[IDX_W-1:0] : query_index;
						if (action == ACT_CLEAR) begin
							count_q <= '0;
							root_vld_q <= 1'b0;
							st_q <= ST_OK;
							state_q <= S_OUT;
						end else if (action == ACT_APPEND && !full) begin
							st_q <= ST_OK;
							state_q <= S_POP;
						end else if (action == ACT_APPEND) begin
							st_q <= ST_FULL;
							state_q <= S_OUT;
						end else if (action == ACT_QUERY) begin
							if ({1'b0, query_index} >= count_q) begin
								st_q <= ST_ABSENT;
								state_q <= S_OUT;
							end else begin
								st_q <= ST_OK;
								state_q <= S_READ;
							end
						end else begin
							st_q <= ST_OK;
							state_q <= S_OUT;
						end
					end
				end
				S_POP: begin
					if (pop) begin
						cand_q <= cn[0];
						cand_vld_q <= 1'b1;
					end else begin
						if (!cv[0]) begin
							root_q <= idx_q;
							root_vld_q <= 1'b1;
						end
						count_q <= count_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_OUT;
				S_OUT: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The link memory takes one write per cycle. At the push the new node's record is
	// written, the node under it gets its right link in the READ cycle, and the last
	// popped node, which becomes the left child, gets its new parent in the OUT cycle.
	// Other popped nodes keep their records unchanged.
	links_t new_rec;
	logic [IDX_W-1:0] par_q;
	logic par_vld_q;
	logic [AW-1:0] wa;
	links_t wd;
	logic we;
	links_t pr_q;

	always_comb begin
		new_rec = '0;
		new_rec.left = cand_vld_q ? cand_q : '0;
		new_rec.has_left = cand_vld_q;
		new_rec.parent = cv[0] ? cn[0] : '0;
		new_rec.has_parent = cv[0];
		we = 1'b0;
		wa = '0;
		wd = '0;
		if (state_q == S_POP && !pop) begin
			we = 1'b1;
			wa = AW'(idx_q);
			wd = new_rec;
		end else if (state_q == S_READ && act_q == ACT_APPEND && par_vld_q) begin
			we = 1'b1;
			wa = AW'(par_q);
			wd = pr_q;
			wd.right = idx_q;
			wd.has_right = 1'b1;
		end else if (state_q == S_OUT && act_q == ACT_APPEND && cand_vld_q) begin
			we = 1'b1;
			wa = AW'(cand_q);
			wd = cand_rec_q;
			wd.parent = idx_q;
			wd.has_parent = 1'b1;
		end
	end

	// The record of the spine top is fetched ahead into top_rec_q. On a pop the read follows
	// the cell below, which is the top in the next cycle.
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		top_rec_q <= mem[AW'(pop ? cn[1] : cn[0])];
		if (pop) cand_rec_q <= top_rec_q;
		if (state_q == S_POP && !pop) begin
			par_q <= cn[0];
			par_vld_q <= cv[0];
			pr_q <= top_rec_q;
		end
		rd_q <= mem[AW'(idx_q)];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			if (act_q == ACT_APPEND && st_q == ST_OK) begin
				node_index <= idx_q;
				left_child <= cand_vld_q ? cand_q : '0;
				has_left <= cand_vld_q;
				right_child <= '0;
				has_right <= 1'b0;
				parent_node <= par_vld_q ? par_q : '0;
				has_parent <= par_vld_q;
			end else if (act_q == ACT_QUERY && st_q == ST_OK) begin
				node_index <= idx_q;
				left_child <= rd_q.has_left ? rd_q.left : '0;
				has_left <= rd_q.has_left;
				right_child <= rd_q.has_right ? rd_q.right : '0;
				has_right <= rd_q.has_right;
				parent_node <= rd_q.has_parent ? rd_q.parent : '0;
				has_parent <= rd_q.has_parent;
			end else if (act_q == ACT_QUERY) begin
				node_index <= idx_q;
				{left_child, has_left, right_child, has_right, parent_node, has_parent} <= '0;
			end else begin
				node_index <= '0;
				{left_child, has_left, right_child, has_right, parent_node, has_parent} <= '0;
			end
			root_node <= root_vld_q ? root_q : '0;
			has_root <= root_vld_q;
			node_count <= count_q;
			status <= st_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> state_q != S_POP)
		else $error("popping with a result pending");
	assert property (@(posedge clk) disable iff (!arst_n) !(push && pop))
		else $error("spine push and pop together");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(256))
		else $error("node count overflow");
endmodule
`default_nettype wire

FILE: tb/cartesian_tree_builder_tb.sv
// Self-checking testbench for the Cartesian tree builder: directed table, then random
// clears, appends and queries under random sender gaps and receiver stalls.
// Depends on ctb_pkg and the cartesian_tree_builder RTL.
`default_nettype none
module cartesian_tree_builder_tb;
	import ctb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 256;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] node_index;
		logic [7:0] left_child;
		logic has_left;
		logic [7:0] right_child;
		logic has_right;
		logic [7:0] parent_node;
		logic has_parent;
		logic [7:0] root_node;
		logic has_root;
		logic [8:0] node_count;
		logic [1:0] status;
	} tree_reply_t;

	typedef struct {
		logic [1:0] act;
		logic [31:0] key;
		logic [7:0] qidx;
		logic typed;
		tree_reply_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = ACT_CLEAR;
	logic signed [31:0] value = '0;
	logic [7:0] query_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] node_index, left_child, right_child, parent_node, root_node;
	logic has_left, has_right, has_parent, has_root;
	logic [8:0] node_count;
	logic [1:0] status;

	cartesian_tree_builder uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .value(value),
		.query_index(query_index), .out_valid(out_valid), .out_stall(out_stall),
		.node_index(node_index), .left_child(left_child), .has_left(has_left),
		.right_child(right_child), .has_right(has_right), .parent_node(parent_node),
		.has_parent(has_parent), .root_node(root_node), .has_root(has_root),
		.node_count(node_count), .status(status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: a mirror of the tree and its right spine.
	logic order_max;
	int unsigned n_nodes;
	logic root_ok;
	logic [7:0] root_idx;
	int unsigned spine_len;
	logic [31:0] spine_key[CAP];
	logic [7:0] spine_node[CAP];
	logic [7:0] lnk_l[CAP], lnk_r[CAP], lnk_p[CAP];
	logic ok_l[CAP], ok_r[CAP], ok_p[CAP];

	tree_reply_t pending_replies[$];
	int errors = 0;
	int idle_cycles = 0;
	bit long_hold = 1'b0;

	function automatic void queue_reply(tree_reply_t r);
		pending_replies.insert(pending_replies.size(), r);
	endfunction

	function automatic tree_reply_t tree_view(logic [7:0] idx, bit show, logic [1:0] st);
		tree_reply_t r;
		r = '0;
		if (show) begin
			r.node_index = idx;
			if (ok_l[idx]) begin r.left_child = lnk_l[idx]; r.has_left = 1'b1; end
			if (ok_r[idx]) begin r.right_child = lnk_r[idx]; r.has_right = 1'b1; end
			if (ok_p[idx]) begin r.parent_node = lnk_p[idx]; r.has_parent = 1'b1; end
		end
		if (root_ok) begin r.root_node = root_idx; r.has_root = 1'b1; end
		r.node_count = n_nodes[8:0];
		r.status = st;
		return r;
	endfunction

	function automatic tree_reply_t build_step(logic [1:0] act, logic [31:0] key,
			logic [7:0] qidx);
		logic [31:0] k;
		logic [7:0] cand, i;
		bit cand_ok, keep;
		tree_reply_t r;
		if (act == ACT_CLEAR) begin
			n_nodes = 0; root_ok = 1'b0; root_idx = '0; spine_len = 0;
			return tree_view('0, 1'b0, ST_OK);
		end
		if (act == ACT_APPEND) begin
			if (n_nodes >= CAP) return tree_view('0, 1'b0, ST_FULL);
			// Flipping the sign bit makes unsigned compare follow signed order.
			k = key ^ 32'h8000_0000;
			i = n_nodes[7:0];
			cand = '0; cand_ok = 1'b0;
			while (spine_len > 0) begin
				keep = order_max ? (spine_key[spine_len-1] > k) : (spine_key[spine_len-1] < k);
				if (keep) break;
				cand = spine_node[spine_len-1]; cand_ok = 1'b1;
				spine_len--;
			end
			lnk_l[i] = cand; ok_l[i] = cand_ok;
			if (cand_ok) begin lnk_p[cand] = i; ok_p[cand] = 1'b1; end
			lnk_r[i] = '0; ok_r[i] = 1'b0;
			if (spine_len == 0) begin
				root_idx = i; root_ok = 1'b1; lnk_p[i] = '0; ok_p[i] = 1'b0;
			end else begin
				lnk_r[spine_node[spine_len-1]] = i; ok_r[spine_node[spine_len-1]] = 1'b1;
				lnk_p[i] = spine_node[spine_len-1]; ok_p[i] = 1'b1;
			end
			spine_key[spine_len] = k; spine_node[spine_len] = i; spine_len++;
			n_nodes++;
			return tree_view(i, 1'b1, ST_OK);
		end
		if (act == ACT_QUERY) begin
			if (qidx >= n_nodes) begin
				r = tree_view('0, 1'b0, ST_ABSENT);
				r.node_index = qidx;
				return r;
			end
			return tree_view(qidx, 1'b1, ST_OK);
		end
		return tree_view('0, 1'b0, ST_OK);
	endfunction

	// Offers one item and holds it until the transfer happens. Valid stays high so that
	// the next item can follow at once; the sender drops it when it goes idle.
	task automatic send_item(logic [1:0] act, logic [31:0] key, logic [7:0] qidx,
			bit typed, tree_reply_t want);
		tree_reply_t p;
		action <= act; value <= key; query_index <= qidx; in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		p = build_step(act, key, qidx);
		if (typed && p !== want) begin
			$display("%0t typed row disagrees with predictor: expected %h, predicted %h",
				$time, want, p);
			errors++;
		end
		queue_reply(typed ? want : p);
		@(negedge clk);
	endtask

	task automatic sender_idle(int unsigned cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic send_random(bit gaps);
		int unsigned pick;
		logic [1:0] act;
		logic [31:0] key;
		logic [7:0] qidx;
		pick = $urandom_range(99);
		key = $urandom();
		if ($urandom_range(3) == 0) key = $urandom_range(7) - 4;
		qidx = (pick < 70) ? 8'($urandom_range(n_nodes + 3 > 255 ? 255 : n_nodes + 3))
			: 8'($urandom());
		if (pick < 60) act = ACT_APPEND;
		else if (pick < 90) act = ACT_QUERY;
		else if (pick < 93) act = ACT_CLEAR;
		else act = 2'd3;
		send_item(act, key, qidx, 1'b0, '0);
		if (gaps && $urandom_range(3) == 0) sender_idle($urandom_range(1, 6));
	endtask

	task automatic drain_and_config(logic om);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1; cfg_wdata <= om;
		@(negedge clk);
		cfg_we <= 1'b0;
		order_max = om;
	endtask

	// Receiver: its own stall pattern, plus one long hold-off.
	initial begin
		int unsigned phase;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else begin
				phase++;
				if ((phase / 64) % 3 == 0) out_stall <= 1'b0;
				else out_stall <= ($urandom_range(2) == 0);
			end
		end
	end

	always @(posedge clk) begin
		tree_reply_t got, want;
		if (arst_n) begin
			idle_cycles <= (out_valid && !out_stall) || (in_valid && !in_stall)
				? 0 : idle_cycles + 1;
			if (out_valid && !out_stall) begin
				got = '{node_index, left_child, has_left, right_child, has_right, parent_node,
					has_parent, root_node, has_root, node_count, status};
				if (pending_replies.size() == 0) begin
					$display("%0t unexpected result %h", $time, got);
					errors++;
				end else begin
					want = pending_replies.pop_front();
					if (got !== want) begin
						$display("%0t mismatch: expected %h, actual %h", $time, want, got);
						errors++;
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog expired", $time);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	stim_row_t table_rows[$];

	function automatic stim_row_t row(logic [1:0] a, logic [31:0] k, logic [7:0] q,
			logic typed, tree_reply_t w);
		stim_row_t s;
		s.act = a; s.key = k; s.qidx = q; s.typed = typed; s.want = w;
		return s;
	endfunction

	function automatic void add_row(stim_row_t s);
		table_rows.insert(table_rows.size(), s);
	endfunction

	initial begin
		tree_reply_t z;
		z = '0;
		order_max = 1'b0; n_nodes = 0; root_ok = 1'b0; root_idx = '0; spine_len = 0;
		for (int j = 0; j < CAP; j++) begin
			ok_l[j] = 1'b0; ok_r[j] = 1'b0; ok_p[j] = 1'b0;
			lnk_l[j] = '0; lnk_r[j] = '0; lnk_p[j] = '0;
		end
		// Directed rows; typed results only for the empty tree, the first appends and the closing clear.
		add_row(row(ACT_QUERY, 0, 0, 1, '{8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			ST_ABSENT}));
		add_row(row(2'd3, 0, 0, 1, z));
		add_row(row(ACT_APPEND, 32'h7FFF_FFFF, 0, 1,
			'{8'd0, 0, 0, 0, 0, 0, 0, 8'd0, 1, 9'd1, ST_OK}));
		add_row(row(ACT_APPEND, 32'h8000_0000, 0, 1,
			'{8'd1, 8'd0, 1, 0, 0, 0, 0, 8'd1, 1, 9'd2, ST_OK}));
		add_row(row(ACT_APPEND, 32'h8000_0000, 0, 0, z));
		add_row(row(ACT_APPEND, 32'd5, 0, 0, z));
		add_row(row(ACT_APPEND, 32'hFFFF_FFFF, 0, 0, z));
		add_row(row(ACT_APPEND, 32'd0, 0, 0, z));
		for (int j = 0; j < 6; j++) add_row(row(ACT_QUERY, 0, 8'(j), 0, z));
		add_row(row(ACT_QUERY, 0, 8'hFF, 0, z));
		add_row(row(2'd3, 32'hFFFF_FFFF, 8'hFF, 0, z));
		add_row(row(ACT_CLEAR, 0, 0, 1, z));

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (table_rows[j])
			send_item(table_rows[j].act, table_rows[j].key, table_rows[j].qidx,
				table_rows[j].typed, table_rows[j].want);

		// Fill to capacity under max order, with the output held off for a while.
		drain_and_config(1'b1);
		long_hold = 1'b1;
		for (int j = 0; j < CAP; j++) send_item(ACT_APPEND, $urandom_range(40), 0, 1'b0, z);
		send_item(ACT_APPEND, 32'h7FFF_FFFF, 0, 1'b0, z);
		send_item(ACT_QUERY, 0, 8'hFF, 1'b0, z);
		send_item(ACT_QUERY, 0, 8'd0, 1'b0, z);
		send_item(ACT_CLEAR, 0, 0, 1'b0, z);

		for (int ph = 0; ph < 4; ph++) begin
			drain_and_config(ph[0]);
			for (int j = 0; j < 120; j++) send_random(1'b1);
			for (int j = 0; j < 30; j++) send_random(1'b0);
		end
		// Order switch in the middle of a build.
		drain_and_config(1'b0);
		for (int j = 0; j < 20; j++) send_item(ACT_APPEND, $urandom(), 0, 1'b0, z);
		drain_and_config(1'b1);
		for (int j = 0; j < 40; j++) send_random(1'b1);

		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
rtl/core/ctb_pkg.sv
rtl/core/ctb_cell.sv
rtl/core/cartesian_tree_builder.sv
tb/cartesian_tree_builder_tb.sv
